[src/acs_pkg.sv]
package acs_pkg;

  // default store sizes
  localparam int unsigned MAIN_DEPTH_DEF = 2048;
  localparam int unsigned IO_DEPTH_DEF   = 32;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request operation codes
  localparam logic [2:0] OPER_WR_MAIN = 3'd0;
  localparam logic [2:0] OPER_WR_IO   = 3'd1;
  localparam logic [2:0] OPER_EXEC    = 3'd2;
  localparam logic [2:0] OPER_RD_MAIN = 3'd3;
  localparam logic [2:0] OPER_RD_IO   = 3'd4;

  // instruction opcodes
  localparam logic [4:0] OP_WM   = 5'h01;
  localparam logic [4:0] OP_RM   = 5'h02;
  localparam logic [4:0] OP_BR   = 5'h03;
  localparam logic [4:0] OP_RIO  = 5'h04;
  localparam logic [4:0] OP_WIO  = 5'h05;
  localparam logic [4:0] OP_WB   = 5'h06;
  localparam logic [4:0] OP_WIB  = 5'h07;
  localparam logic [4:0] OP_WACC = 5'h09;
  localparam logic [4:0] OP_RACC = 5'h0B;
  localparam logic [4:0] OP_SWAP = 5'h0E;
  localparam logic [4:0] OP_BRLT = 5'h11;
  localparam logic [4:0] OP_BRGT = 5'h12;
  localparam logic [4:0] OP_BRNE = 5'h13;
  localparam logic [4:0] OP_BRE  = 5'h14;
  localparam logic [4:0] OP_SHR  = 5'h15;
  localparam logic [4:0] OP_SHL  = 5'h16;
  localparam logic [4:0] OP_XOR  = 5'h17;
  localparam logic [4:0] OP_NOT  = 5'h18;
  localparam logic [4:0] OP_OR   = 5'h19;
  localparam logic [4:0] OP_AND  = 5'h1A;
  localparam logic [4:0] OP_MUL  = 5'h1B;
  localparam logic [4:0] OP_SUB  = 5'h1D;
  localparam logic [4:0] OP_ADD  = 5'h1E;
  localparam logic [4:0] OP_EOP  = 5'h1F;

  // request class decided by the front
  typedef enum logic [2:0] {
    K_WR_MAIN,
    K_WR_IO,
    K_EXEC,
    K_RD_MAIN,
    K_RD_IO,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] address;
    logic [7:0]  value;
  } acs_cmd_t;

  // one queue slot with its valid mark
  typedef struct packed {
    logic     valid;
    acs_cmd_t cmd;
  } acs_slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_LO,
    S_DECODE,
    S_EXEC,
    S_RD_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic zf;
    logic cf;
    logic sf;
    logic of;
  } flags_t;

  // reduce an 11-bit address below depth by conditional subtraction
  function automatic logic [10:0] wrap_index(input logic [10:0] a, input int unsigned depth);
    logic [13:0] x;
    logic [13:0] d1;
    logic [13:0] d2;
    logic [13:0] d4;
    x  = {3'b000, a};
    d1 = 14'(depth);
    d2 = 14'(depth * 2);
    d4 = 14'(depth * 4);
    if (x >= d4) x = x - d4;
    if (x >= d2) x = x - d2;
    if (x >= d1) x = x - d1;
    return x[10:0];
  endfunction

endpackage

[src/acs_if.sv]
interface acs_req_if;
  import acs_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [10:0] address;
  logic [7:0]  value;

  modport source (output valid, output operation, output address, output value,
                  input ready);
  modport sink (input valid, input operation, input address, input value,
                output ready);
endinterface

interface acs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [10:0] pc_out;
  logic [15:0] ir_out;
  logic [7:0]  acc_out;
  logic [7:0]  mbr_out;
  logic [7:0]  iobr_out;
  logic [7:0]  flags_out;
  logic        halted_out;

  modport source (output valid, output read_data, output pc_out, output ir_out,
                  output acc_out, output mbr_out, output iobr_out, output flags_out,
                  output halted_out, input ready);
  modport sink (input valid, input read_data, input pc_out, input ir_out,
                input acc_out, input mbr_out, input iobr_out, input flags_out,
                input halted_out, output ready);
endinterface

[src/acs_front.sv]
module acs_front
  import acs_pkg::*;
(
  acs_req_if.sink   req,
  input  logic      full,
  output acs_slot_t push
);

  kind_t kind;

  // classify the request operation
  always_comb begin
    unique case (req.operation)
      OPER_WR_MAIN: kind = K_WR_MAIN;
      OPER_WR_IO:   kind = K_WR_IO;
      OPER_EXEC:    kind = K_EXEC;
      OPER_RD_MAIN: kind = K_RD_MAIN;
      OPER_RD_IO:   kind = K_RD_IO;
      default:      kind = K_NONE;
    endcase
  end

  // accept whenever the queue has room
  assign req.ready        = !full;
  assign push.valid       = req.valid && !full;
  assign push.cmd.kind    = kind;
  assign push.cmd.address = req.address;
  assign push.cmd.value   = req.value;

endmodule

[src/acs_queue.sv]
module acs_queue
  import acs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  acs_slot_t push,
  input  logic      pop,
  output logic      full,
  output acs_slot_t head
);

  acs_cmd_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // pointer and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

[src/acs_back.sv]
module acs_back
  import acs_pkg::*;
#(
  parameter int unsigned MAIN_DEPTH = MAIN_DEPTH_DEF,
  parameter int unsigned IO_DEPTH   = IO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  acs_slot_t head,
  output logic      pop,
  acs_rsp_if.source rsp
);

  localparam int unsigned MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int unsigned IO_AW   = $clog2(IO_DEPTH);

  state_t state;
  state_t state_next;

  // architectural registers
  logic [10:0] pc;
  logic [15:0] ir;
  logic [7:0]  acc;
  logic [7:0]  mbr;
  logic [7:0]  iobr;
  flags_t      flags;
  logic        halt;
  logic [7:0]  rd;
  kind_t       cur_kind;

  // stores
  logic [7:0]         main_mem [MAIN_DEPTH];
  logic [7:0]         io_mem [IO_DEPTH];
  logic [7:0]         main_q;
  logic [7:0]         io_q;
  logic               main_we;
  logic [MAIN_AW-1:0] main_addr;
  logic               io_we;
  logic [IO_AW-1:0]   io_addr;
  logic [7:0]         io_wdata;
  logic [7:0]         main_wdata;

  // output register
  logic out_valid;
  logic out_load;

  // decode of the freshly fetched word
  logic [15:0] word;
  logic [4:0]  dec_op;
  logic [10:0] dec_arg;
  assign word    = {ir[15:8], main_q};
  assign dec_op  = word[15:11];
  assign dec_arg = word[10:0];

  // store indexes
  logic [10:0] pc_wrap;
  logic [10:0] head_main_wrap;
  logic [10:0] head_io_wrap;
  logic [10:0] arg_main_wrap;
  logic [10:0] arg_io_wrap;
  assign pc_wrap        = wrap_index(pc, MAIN_DEPTH);
  assign head_main_wrap = wrap_index(head.cmd.address, MAIN_DEPTH);
  assign head_io_wrap   = wrap_index({6'b000000, head.cmd.address[4:0]}, IO_DEPTH);
  assign arg_main_wrap  = wrap_index(dec_arg, MAIN_DEPTH);
  assign arg_io_wrap    = wrap_index({6'b000000, dec_arg[4:0]}, IO_DEPTH);

  // main store, one port
  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_addr] <= main_wdata;
    end
    main_q <= main_mem[main_addr];
  end

  // io store, one port
  always_ff @(posedge clk) begin
    if (io_we) begin
      io_mem[io_addr] <= io_wdata;
    end
    io_q <= io_mem[io_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and store controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    main_we    = 1'b0;
    main_addr  = pc_wrap[MAIN_AW-1:0];
    main_wdata = head.cmd.value;
    io_we      = 1'b0;
    io_addr    = head_io_wrap[IO_AW-1:0];
    io_wdata   = head.cmd.value;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.cmd.kind)
            K_WR_MAIN: begin
              main_we    = 1'b1;
              main_addr  = head_main_wrap[MAIN_AW-1:0];
              state_next = S_RESP;
            end
            K_WR_IO: begin
              io_we      = 1'b1;
              state_next = S_RESP;
            end
            K_RD_MAIN: begin
              main_addr  = head_main_wrap[MAIN_AW-1:0];
              state_next = S_RD_WAIT;
            end
            K_RD_IO: begin
              state_next = S_RD_WAIT;
            end
            K_EXEC: begin
              state_next = halt ? S_RESP : S_FETCH_LO;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_FETCH_LO: begin
        state_next = S_DECODE;
      end
      S_DECODE: begin
        main_addr  = arg_main_wrap[MAIN_AW-1:0];
        main_wdata = mbr;
        main_we    = (dec_op == OP_WM);
        io_addr    = arg_io_wrap[IO_AW-1:0];
        io_wdata   = iobr;
        io_we      = (dec_op == OP_WIO);
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RD_WAIT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // alu on acc and mbr
  logic        alu_neg;
  logic [7:0]  alu_b;
  logic [8:0]  alu_sum;
  logic [15:0] alu_prod;
  logic [7:0]  alu_res;
  flags_t      alu_flags;
  logic        alu_take;
  logic [4:0]  op;
  assign op = ir[15:11];

  always_comb begin
    alu_neg   = (op != OP_ADD);
    alu_b     = alu_neg ? (~mbr + 8'd1) : mbr;
    alu_sum   = {1'b0, acc} + {1'b0, alu_b};
    alu_prod  = {8'h00, acc} * {8'h00, mbr};
    alu_res   = alu_sum[7:0];
    alu_flags = '{zf: 1'b0, cf: 1'b0, sf: 1'b0, of: 1'b0};
    unique case (op)
      OP_MUL: begin
        alu_res      = alu_prod[7:0];
        alu_flags.cf = |alu_prod[15:8];
        alu_flags.of = |alu_prod[15:8];
      end
      OP_AND: alu_res = acc & mbr;
      OP_OR:  alu_res = acc | mbr;
      OP_NOT: alu_res = ~acc;
      OP_XOR: alu_res = acc ^ mbr;
      OP_SHL: begin
        alu_res      = {acc[6:0], 1'b0};
        alu_flags.cf = acc[7];
      end
      OP_SHR: begin
        alu_res      = {1'b0, acc[7:1]};
        alu_flags.cf = acc[0];
      end
      default: begin
        alu_flags.cf = alu_sum[8];
        if (!alu_neg) begin
          alu_flags.of = (acc[7] == mbr[7]) && (acc[7] != alu_sum[7]);
        end else begin
          alu_flags.of = (acc[7] != mbr[7]) && (acc[7] != alu_sum[7]);
        end
      end
    endcase
    alu_flags.zf = (alu_res == 8'h00);
    alu_flags.sf = alu_res[7];
    // compare-branch decision on the new flags
    unique case (op)
      OP_BRE:  alu_take = alu_flags.zf;
      OP_BRNE: alu_take = !alu_flags.zf;
      OP_BRGT: alu_take = !alu_flags.sf;
      OP_BRLT: alu_take = alu_flags.sf;
      default: alu_take = 1'b0;
    endcase
  end

  // architectural register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      ir       <= '0;
      acc      <= '0;
      mbr      <= '0;
      iobr     <= '0;
      flags    <= '{zf: 1'b0, cf: 1'b0, sf: 1'b0, of: 1'b0};
      halt     <= 1'b0;
      rd       <= '0;
      cur_kind <= K_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur_kind <= head.cmd.kind;
            rd       <= '0;
            if (head.cmd.kind == K_EXEC && !halt) begin
              pc <= pc + 11'd1;
            end
          end
        end
        S_FETCH_LO: begin
          ir[15:8] <= main_q;
          pc       <= pc + 11'd1;
        end
        S_DECODE: begin
          ir <= word;
        end
        S_EXEC: begin
          unique case (op)
            OP_RM:   mbr  <= main_q;
            OP_BR:   pc   <= ir[10:0];
            OP_RIO:  iobr <= io_q;
            OP_WB:   mbr  <= ir[7:0];
            OP_WIB:  iobr <= ir[7:0];
            OP_WACC: acc  <= mbr;
            OP_RACC: mbr  <= acc;
            OP_SWAP: begin
              mbr  <= iobr;
              iobr <= mbr;
            end
            OP_ADD, OP_SUB, OP_BRE, OP_BRNE, OP_BRGT, OP_BRLT, OP_MUL,
            OP_AND, OP_OR, OP_NOT, OP_XOR, OP_SHL, OP_SHR: begin
              acc   <= alu_res;
              flags <= alu_flags;
              if (alu_take) begin
                pc <= ir[10:0];
              end
            end
            OP_EOP:  halt <= 1'b1;
            default: begin
            end
          endcase
        end
        S_RD_WAIT: begin
          rd <= (cur_kind == K_RD_MAIN) ? main_q : io_q;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.read_data  <= rd;
      rsp.pc_out     <= pc;
      rsp.ir_out     <= ir;
      rsp.acc_out    <= acc;
      rsp.mbr_out    <= mbr;
      rsp.iobr_out   <= iobr;
      rsp.flags_out  <= {flags.of, 4'b0000, flags.sf, flags.cf, flags.zf};
      rsp.halted_out <= halt;
    end
  end

  assign rsp.valid = out_valid;

endmodule

[src/accumulator_cpu_step_unit.sv]
// Eight-bit accumulator machine stepped one request at a time. A request
// writes or reads one byte of the main store or the io store, or executes a
// single instruction; every request gives exactly one response carrying the
// read byte and the machine registers after it. Requests enter a two-entry
// queue, so up to two may be taken while the core is busy or a response waits.
// Execute steps: high fetch, low fetch, decode with the data access,
// execute, response; reads pass a read wait, and writes and other requests
// go straight to response; the main store has one port. An execute request
// while halted goes straight to response, changes nothing. No clearing pass.
module accumulator_cpu_step_unit
  import acs_pkg::*;
#(
  parameter int unsigned MAIN_DEPTH = MAIN_DEPTH_DEF,
  parameter int unsigned IO_DEPTH   = IO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  acs_req_if.sink   req,
  acs_rsp_if.source rsp
);

  acs_slot_t push;
  acs_slot_t head;
  logic      full;
  logic      pop;

  // classify incoming requests
  acs_front u_front (
    .req  (req),
    .full (full),
    .push (push)
  );

  // decoupling queue
  acs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  // execution core with stores and response register
  acs_back #(
    .MAIN_DEPTH (MAIN_DEPTH),
    .IO_DEPTH   (IO_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule
